@@ hdl/vertex_transform_2d_defines.svh @@
// ----------------------------------------------------------------------------
// vertex_transform_2d_defines
// Assertion macros shared by the vertex transform RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_2D_DEFINES_SVH
`define VERTEX_TRANSFORM_2D_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vt2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt2d_pkg
// Types, codes and fixed-point constants of the 2-D vertex transform.
// ----------------------------------------------------------------------------
package vt2d_pkg;

  localparam int COORD_BITS      = 16;
  localparam int CFG_BITS        = 16;
  localparam int TRIG_FRAC_BITS  = 14;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int IDX_BITS        = 5;
  localparam int ADDR_BITS       = 3;

  localparam int OPB_BITS  = CFG_BITS + 1;
  localparam int PROD_BITS = COORD_BITS + OPB_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  localparam int IN_DATA_BITS  = ((2 * COORD_BITS + IDX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_SCALE     = 3'd1,
    MODE_ROTATE    = 3'd2,
    MODE_REFLECT   = 3'd3,
    MODE_SHEAR     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_SWAP = 2'd2,
    AXIS_NEG  = 2'd3
  } axis_e;

  typedef enum logic [ADDR_BITS-1:0] {
    REG_MODE     = 3'd0,
    REG_AXIS     = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_FACTOR_X = 3'd4,
    REG_FACTOR_Y = 3'd5,
    REG_COS      = 3'd6,
    REG_SIN      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHIFT_NONE  = 2'd0,
    SHIFT_SCALE = 2'd1,
    SHIFT_TRIG  = 2'd2
  } shift_e;

  localparam logic [IDX_BITS-1:0] IDX_1 = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] IDX_2 = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] IDX_3 = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] IDX_4 = IDX_BITS'(4);

  localparam logic signed [OPB_BITS-1:0] B_ZERO    = '0;
  localparam logic signed [OPB_BITS-1:0] B_ONE     = OPB_BITS'(1);
  localparam logic signed [OPB_BITS-1:0] B_TWO     = OPB_BITS'(2);
  localparam logic signed [OPB_BITS-1:0] B_NEG_ONE = '1;

  localparam logic signed [SUM_BITS-1:0] RND_SCALE = SUM_BITS'(2 ** (SCALE_FRAC_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] RND_TRIG  = SUM_BITS'(2 ** (TRIG_FRAC_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_MAX   = SUM_BITS'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_MIN   = -SAT_MAX - SUM_BITS'(1);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  // one output coordinate = a1*b1 + a2*b2
  typedef struct packed {
    logic signed [COORD_BITS-1:0] a1;
    logic signed [OPB_BITS-1:0]   b1;
    logic signed [COORD_BITS-1:0] a2;
    logic signed [OPB_BITS-1:0]   b2;
  } coord_op_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] p1;
    logic signed [PROD_BITS-1:0] p2;
  } coord_prod_t;

endpackage

@@ hdl/vertex_transform_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_2d
// Four-stage pipeline applying translate, scale, rotate, reflect or shear
// to one polygon vertex per item.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata {vertex_index, y_in, x_in}, tlast last_in
// m_axis    out  tdata {y_out, x_out}, tuser clipped, tlast last_out
// cfg       in   cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// One item per clock unless m_axis_tready stalls; stages are operand select,
// multiply, sum/round, saturate. The two 16x17 multipliers per coordinate set
// the throughput, one product set per cycle. A stall holds each full stage;
// empty stages still fill, so s_axis_tready drops only with all four full.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "vertex_transform_2d_defines.svh"

module vertex_transform_2d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vt2d_pkg::ADDR_BITS-1:0]       cfg_addr_i,
  input  logic [vt2d_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // x_in [15:0], y_in [31:16], vertex_index [36:32], zero pad
  input  logic [vt2d_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // x_out [15:0], y_out [31:16]
  output logic [vt2d_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // clipped [0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  import vt2d_pkg::*;

  localparam int NSTAGE = 4;

  // configuration registers
  logic [2:0]                   mode_q;
  logic [1:0]                   axis_q;
  logic signed [CFG_BITS-1:0]   offx_q, offy_q, facx_q, facy_q, cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TRANSLATE;
      axis_q <= AXIS_X;
      offx_q <= '0;
      offy_q <= '0;
      facx_q <= CFG_BITS'(256);
      facy_q <= CFG_BITS'(256);
      cos_q  <= CFG_BITS'(16384);
      sin_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_MODE:     mode_q <= cfg_wdata_i[2:0];
        REG_AXIS:     axis_q <= cfg_wdata_i[1:0];
        REG_OFFSET_X: offx_q <= cfg_wdata_i;
        REG_OFFSET_Y: offy_q <= cfg_wdata_i;
        REG_FACTOR_X: facx_q <= cfg_wdata_i;
        REG_FACTOR_Y: facy_q <= cfg_wdata_i;
        REG_COS:      cos_q  <= cfg_wdata_i;
        REG_SIN:      sin_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage control: a stage loads when empty or when it moves on
  logic [NSTAGE-1:0] valid_q, valid_d, load;

  always_comb begin
    load[NSTAGE-1] = !valid_q[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = load[0];

  // stage A: operand select
  logic signed [COORD_BITS-1:0] x_in, y_in;
  logic [IDX_BITS-1:0]          idx_in;
  logic signed [OPB_BITS-1:0]   wx, wy;
  coord_op_t                    op_x_d, op_y_d, op_x_q, op_y_q;
  shift_e                       shift_d, shift_a_q, shift_b_q;
  logic                         last_a_q, last_b_q, last_c_q, last_q;

  assign x_in   = s_axis_tdata[COORD_BITS-1:0];
  assign y_in   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign idx_in = s_axis_tdata[2*COORD_BITS+IDX_BITS-1:2*COORD_BITS];

  always_comb begin
    wx = B_ZERO;
    wy = B_ZERO;
    unique case (axis_e'(axis_q))
      AXIS_X: begin
        if (idx_in >= IDX_1 && idx_in <= IDX_3) wx = B_ONE;
      end
      AXIS_Y: begin
        if (idx_in >= IDX_2 && idx_in <= IDX_4) wy = B_ONE;
      end
      AXIS_SWAP: begin
        priority if (idx_in == IDX_1 || idx_in == IDX_4) begin
          wx = B_ONE;
          wy = B_ONE;
        end else if (idx_in == IDX_2 || idx_in == IDX_3) begin
          wx = B_TWO;
          wy = B_TWO;
        end else begin
          wx = B_ZERO;
        end
      end
      default: wx = B_ZERO;
    endcase
  end

  always_comb begin
    op_x_d  = '{a1: x_in, b1: B_ONE, a2: '0, b2: B_ZERO};
    op_y_d  = '{a1: y_in, b1: B_ONE, a2: '0, b2: B_ZERO};
    shift_d = SHIFT_NONE;
    unique case (mode_e'(mode_q))
      MODE_TRANSLATE: begin
        op_x_d.a2 = offx_q;
        op_x_d.b2 = B_ONE;
        op_y_d.a2 = offy_q;
        op_y_d.b2 = B_ONE;
      end
      MODE_SCALE: begin
        op_x_d.b1 = OPB_BITS'(facx_q);
        op_y_d.b1 = OPB_BITS'(facy_q);
        shift_d   = SHIFT_SCALE;
      end
      MODE_ROTATE: begin
        op_x_d.b1 = OPB_BITS'(cos_q);
        op_x_d.a2 = y_in;
        op_x_d.b2 = -OPB_BITS'(sin_q);
        op_y_d.a1 = x_in;
        op_y_d.b1 = OPB_BITS'(sin_q);
        op_y_d.a2 = y_in;
        op_y_d.b2 = OPB_BITS'(cos_q);
        shift_d   = SHIFT_TRIG;
      end
      MODE_REFLECT: begin
        unique case (axis_e'(axis_q))
          AXIS_X: op_y_d.b1 = B_NEG_ONE;
          AXIS_Y: op_x_d.b1 = B_NEG_ONE;
          AXIS_SWAP: begin
            op_x_d.a1 = y_in;
            op_y_d.a1 = x_in;
          end
          AXIS_NEG: begin
            op_x_d.a1 = y_in;
            op_x_d.b1 = B_NEG_ONE;
            op_y_d.a1 = x_in;
            op_y_d.b1 = B_NEG_ONE;
          end
          default: ;
        endcase
      end
      MODE_SHEAR: begin
        op_x_d.a2 = offx_q;
        op_x_d.b2 = wx;
        op_y_d.a2 = offy_q;
        op_y_d.b2 = wy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      op_x_q    <= op_x_d;
      op_y_q    <= op_y_d;
      shift_a_q <= shift_d;
      last_a_q  <= s_axis_tlast;
    end
  end

  // stage B: products
  coord_prod_t prod_x_q, prod_y_q;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      prod_x_q.p1 <= PROD_BITS'($signed(op_x_q.a1) * $signed(op_x_q.b1));
      prod_x_q.p2 <= PROD_BITS'($signed(op_x_q.a2) * $signed(op_x_q.b2));
      prod_y_q.p1 <= PROD_BITS'($signed(op_y_q.a1) * $signed(op_y_q.b1));
      prod_y_q.p2 <= PROD_BITS'($signed(op_y_q.a2) * $signed(op_y_q.b2));
      shift_b_q   <= shift_a_q;
      last_b_q    <= last_a_q;
    end
  end

  // stage C: sum, then in scale and rotate modes round half up and scale down
  logic signed [SUM_BITS-1:0] sum_x, sum_y, res_x_d, res_y_d, res_x_q, res_y_q;

  assign sum_x = SUM_BITS'($signed(prod_x_q.p1)) + SUM_BITS'($signed(prod_x_q.p2));
  assign sum_y = SUM_BITS'($signed(prod_y_q.p1)) + SUM_BITS'($signed(prod_y_q.p2));

  always_comb begin
    unique case (shift_b_q)
      SHIFT_SCALE: begin
        res_x_d = (sum_x + RND_SCALE) >>> SCALE_FRAC_BITS;
        res_y_d = (sum_y + RND_SCALE) >>> SCALE_FRAC_BITS;
      end
      SHIFT_TRIG: begin
        res_x_d = (sum_x + RND_TRIG) >>> TRIG_FRAC_BITS;
        res_y_d = (sum_y + RND_TRIG) >>> TRIG_FRAC_BITS;
      end
      default: begin
        res_x_d = sum_x;
        res_y_d = sum_y;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      res_x_q  <= res_x_d;
      res_y_q  <= res_y_d;
      last_c_q <= last_b_q;
    end
  end

  // stage D: saturate
  logic signed [COORD_BITS-1:0] out_x_d, out_y_d, out_x_q, out_y_q;
  logic                         clip_x, clip_y, clip_q;

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    priority if (res_x_q > SAT_MAX) begin
      out_x_d = COORD_MAX;
    end else if (res_x_q < SAT_MIN) begin
      out_x_d = COORD_MIN;
    end else begin
      out_x_d = res_x_q[COORD_BITS-1:0];
      clip_x  = 1'b0;
    end
    priority if (res_y_q > SAT_MAX) begin
      out_y_d = COORD_MAX;
    end else if (res_y_q < SAT_MIN) begin
      out_y_d = COORD_MIN;
    end else begin
      out_y_d = res_y_q[COORD_BITS-1:0];
      clip_y  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      clip_q  <= clip_x | clip_y;
      last_q  <= last_c_q;
    end
  end

  assign m_axis_tvalid = valid_q[NSTAGE-1];
  assign m_axis_tdata  = OUT_DATA_BITS'({out_y_q, out_x_q});
  assign m_axis_tuser  = clip_q;
  assign m_axis_tlast  = last_q;

  // checks
  `VT_ASSERT_SAME(a_full_stall, !s_axis_tready, &valid_q, "input stalled with a free stage")
  `VT_ASSERT_NEXT(a_accept_fill, s_axis_tvalid && s_axis_tready, valid_q[0],
                  "accepted item not in first stage")
  `VT_ASSERT_SAME(a_clip_edge, m_axis_tvalid && m_axis_tuser,
                  out_x_q == COORD_MAX || out_x_q == COORD_MIN ||
                  out_y_q == COORD_MAX || out_y_q == COORD_MIN,
                  "clipped item without a saturated coordinate")

endmodule
